@@ hdl/abc_pkg.sv @@
// Shared types and constants for the arcade button conditioner.
`default_nettype none

package abc_pkg;

  // Widths of the configuration port and timestamps.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned StampW   = 32;
  localparam int unsigned PeriodW  = CfgDataW + 1;

  // Remainder unit takes one dividend bit per step.
  localparam int unsigned DivSteps = StampW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SINGLE_MACHINE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HAS_COIN_BUTTON = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AUTOFIRE_ENABLE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_AUTOFIRE_ON_MS  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_AUTOFIRE_OFF_MS = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RESET_HOLD_MS   = 3'd5;

  // Configuration reset values.
  localparam logic [CfgDataW-1:0] AutofireOnReset  = 16'd50;
  localparam logic [CfgDataW-1:0] AutofireOffReset = 16'd50;
  localparam logic [CfgDataW-1:0] ResetHoldReset   = 16'd3000;

  // Virtual coin sequence phase lengths in milliseconds.
  localparam logic [StampW-1:0] CoinPulseMs  = 32'd100;
  localparam logic [StampW-1:0] CoinGapMs    = 32'd500;
  localparam logic [StampW-1:0] StartPulseMs = 32'd100;

  // Virtual coin sequence phases.
  typedef enum logic [2:0] {
    CS_IDLE  = 3'd0,
    CS_COIN  = 3'd1,
    CS_GAP   = 3'd2,
    CS_START = 3'd3,
    CS_HELD  = 3'd4
  } coin_seq_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_DELIVER
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic div_step;
    logic load_out;
  } abc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_needed;
  } abc_status_t;

endpackage

`default_nettype wire

@@ hdl/arcade_button_conditioner.sv @@
// Top level of the arcade button conditioner: controller plus datapath.
//
// Each input request is one button poll with a millisecond timestamp; each
// poll gives exactly one result with the conditioned button byte and flags.
// Both channels use valid and stall; a request moves on a rising edge with
// valid high and stall low. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write it only while the block is
// idle, which the block itself does not enforce; unknown indexes are ignored.
//
// A poll is evaluated in the cycle it is accepted; one poll is in flight at a
// time. The controller loads the output register from ST_DELIVER once it is
// free; with autofire active on a held fire and a nonzero period it first runs
// ST_DIVIDE, where a restoring remainder unit takes one dividend bit per cycle.
//
// Reset restores the configuration defaults and clears all but the result
// registers; the first poll after reset is checked for fire held at power-up.
// When the receiver stalls, the finished result waits in the output register and
// the next poll is accepted; a further result waits until the register is taken.
`default_nettype none

module arcade_button_conditioner
  import abc_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire [CfgIdxW-1:0]  cfg_idx_i,
  input  wire [CfgDataW-1:0] cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                start_pressed_i,
  input  wire                coin_pressed_i,
  input  wire                left_pressed_i,
  input  wire                right_pressed_i,
  input  wire                up_pressed_i,
  input  wire                down_pressed_i,
  input  wire                fire_pressed_i,
  input  wire [StampW-1:0]   now_ms_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [7:0]         buttons_o,
  output logic               fire_unmasked_o,
  output logic               volume_up_o,
  output logic               volume_down_o,
  output logic               reset_request_o,
  output logic               attract_reset_o,
  output logic               play_intent_o,
  output logic               demo_sounds_off_o
);

  abc_cmd_t    cmd;
  abc_status_t status;

  // Sequencing of requests and the remainder unit.
  abc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Button evaluation, timers and result register.
  abc_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .start_pressed_i   (start_pressed_i),
    .coin_pressed_i    (coin_pressed_i),
    .left_pressed_i    (left_pressed_i),
    .right_pressed_i   (right_pressed_i),
    .up_pressed_i      (up_pressed_i),
    .down_pressed_i    (down_pressed_i),
    .fire_pressed_i    (fire_pressed_i),
    .now_ms_i          (now_ms_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .buttons_o         (buttons_o),
    .fire_unmasked_o   (fire_unmasked_o),
    .volume_up_o       (volume_up_o),
    .volume_down_o     (volume_down_o),
    .reset_request_o   (reset_request_o),
    .attract_reset_o   (attract_reset_o),
    .play_intent_o     (play_intent_o),
    .demo_sounds_off_o (demo_sounds_off_o)
  );

endmodule

`default_nettype wire

@@ hdl/abc_ctrl.sv @@
// Controller state machine: request handshake, remainder sequencing, result delivery.
`default_nettype none

module abc_ctrl
  import abc_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  input  abc_status_t status_i,
  output abc_cmd_t    cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // State, step counter and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          cnt_d           = '0;
          state_d         = status_i.div_needed ? ST_DIVIDE : ST_DELIVER;
        end
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = ST_DELIVER;
        end
      end
      ST_DELIVER: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // The output register fills on delivery and empties when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/abc_datapath.sv @@
// Datapath: configuration, button state, timers, autofire remainder and result register.
`default_nettype none

module abc_datapath
  import abc_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [CfgIdxW-1:0]   cfg_idx_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,
  input  wire                 start_pressed_i,
  input  wire                 coin_pressed_i,
  input  wire                 left_pressed_i,
  input  wire                 right_pressed_i,
  input  wire                 up_pressed_i,
  input  wire                 down_pressed_i,
  input  wire                 fire_pressed_i,
  input  wire [StampW-1:0]    now_ms_i,
  input  abc_cmd_t            cmd_i,
  output abc_status_t         status_o,
  output logic [7:0]          buttons_o,
  output logic                fire_unmasked_o,
  output logic                volume_up_o,
  output logic                volume_down_o,
  output logic                reset_request_o,
  output logic                attract_reset_o,
  output logic                play_intent_o,
  output logic                demo_sounds_off_o
);

  // Configuration registers.
  logic                single_machine_q, has_coin_q, af_enable_q;
  logic [CfgDataW-1:0] af_on_q, af_off_q, hold_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_machine_q <= 1'b0;
      has_coin_q       <= 1'b0;
      af_enable_q      <= 1'b0;
      af_on_q          <= AutofireOnReset;
      af_off_q         <= AutofireOffReset;
      hold_ms_q        <= ResetHoldReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SINGLE_MACHINE:  single_machine_q <= cfg_data_i[0];
        CFG_HAS_COIN_BUTTON: has_coin_q       <= cfg_data_i[0];
        CFG_AUTOFIRE_ENABLE: af_enable_q      <= cfg_data_i[0];
        CFG_AUTOFIRE_ON_MS:  af_on_q          <= cfg_data_i;
        CFG_AUTOFIRE_OFF_MS: af_off_q         <= cfg_data_i;
        CFG_RESET_HOLD_MS:   hold_ms_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Persistent state across requests.
  coin_seq_e         seq_q, seq_d;
  logic [StampW-1:0] seq_stamp_q, seq_stamp_d;
  logic [StampW-1:0] hold_stamp_q, hold_stamp_d;
  logic              hold_valid_q, hold_valid_d;
  logic [2:0]        prev_menu_q, prev_menu_d;
  logic [1:0]        prev_sc_q, prev_sc_d;
  logic              suppress_q, suppress_d;
  logic              first_q, first_d;
  logic              demo_q, demo_d;
  logic [StampW-1:0] af_stamp_q, af_stamp_d;
  logic              af_valid_q, af_valid_d;

  // Per-request results held until delivery.
  logic [5:0]         bs_q, bs_d;
  logic [1:0]         sc_q, sc_d;
  logic               fire_unmasked_q, fire_unmasked_d;
  logic               vol_up_q, vol_up_d;
  logic               vol_down_q, vol_down_d;
  logic               rst_req_q, rst_req_d;
  logic               attract_q, attract_d;
  logic               intent_q, intent_d;
  logic               af_active_q, af_active_d;
  logic               period_zero_q;
  logic [PeriodW-1:0] period_q, period_d;
  logic [StampW-1:0]  elapsed_d;

  // Remainder unit registers.
  logic [PeriodW-1:0] rem_q, rem_d;
  logic [StampW-1:0]  dvd_q, dvd_d;

  // Timer differences, all modulo 2^32.
  logic [StampW-1:0] seq_dt, hold_dt, af_dt;
  assign seq_dt  = now_ms_i - seq_stamp_q;
  assign hold_dt = now_ms_i - hold_stamp_q;
  assign af_dt   = now_ms_i - af_stamp_q;

  // Virtual coin sequence.
  always_comb begin
    seq_d       = seq_q;
    seq_stamp_d = seq_stamp_q;
    if (!has_coin_q) begin
      case (seq_q)
        CS_IDLE: begin
          if (start_pressed_i) begin
            seq_d       = CS_COIN;
            seq_stamp_d = now_ms_i;
          end
        end
        CS_COIN: begin
          if (seq_dt > CoinPulseMs) begin
            seq_d       = CS_GAP;
            seq_stamp_d = now_ms_i;
          end
        end
        CS_GAP: begin
          if (seq_dt > CoinGapMs) begin
            seq_d       = CS_START;
            seq_stamp_d = now_ms_i;
          end
        end
        CS_START: begin
          if (seq_dt > StartPulseMs) begin
            seq_d       = CS_HELD;
            seq_stamp_d = now_ms_i;
          end
        end
        CS_HELD: begin
          if (!start_pressed_i) begin
            seq_d = CS_IDLE;
          end
        end
        default: seq_d = CS_IDLE;
      endcase
    end
  end

  // Request evaluation: menu, hold timer, startup blanking, play intent, autofire.
  logic       blank, hold_eff_valid;
  logic [2:0] cur_menu;
  logic [1:0] cur_sc;

  always_comb begin
    sc_d[0] = has_coin_q ? start_pressed_i : (seq_d == CS_START || seq_d == CS_HELD);
    sc_d[1] = has_coin_q ? coin_pressed_i  : (seq_d == CS_COIN);
    cur_sc  = sc_d;

    vol_up_d   = start_pressed_i & up_pressed_i;
    vol_down_d = start_pressed_i & down_pressed_i;
    hold_eff_valid = hold_valid_q & !(vol_up_d | vol_down_d);

    // Long-hold reset and attract edges.
    cur_menu     = {start_pressed_i, down_pressed_i, up_pressed_i};
    attract_d    = 1'b0;
    rst_req_d    = 1'b0;
    prev_menu_d  = prev_menu_q;
    hold_stamp_d = hold_stamp_q;
    hold_valid_d = hold_eff_valid;
    if (!single_machine_q) begin
      attract_d   = |(cur_menu & ~prev_menu_q);
      prev_menu_d = cur_menu;
      if (start_pressed_i) begin
        hold_valid_d = 1'b1;
        if (!hold_eff_valid) begin
          hold_stamp_d = now_ms_i;
        end else if (hold_dt > StampW'(hold_ms_q)) begin
          hold_stamp_d = now_ms_i;
          rst_req_d    = 1'b1;
        end
      end else begin
        hold_valid_d = 1'b0;
      end
    end

    // Fire held at the first poll blanks buttons until fire is released.
    first_d    = 1'b0;
    demo_d     = demo_q | (first_q & fire_pressed_i);
    blank      = (suppress_q | first_q) & fire_pressed_i;
    suppress_d = blank;
    bs_d       = blank ? 6'd0 : {start_pressed_i, fire_pressed_i, down_pressed_i,
                                 up_pressed_i, right_pressed_i, left_pressed_i};
    fire_unmasked_d = bs_d[4];

    intent_d  = (cur_sc != 2'b00) && (prev_sc_q == 2'b00);
    prev_sc_d = cur_sc;

    // Autofire phase: time since fire went down, taken modulo the period.
    period_d    = PeriodW'(af_on_q) + PeriodW'(af_off_q);
    af_active_d = af_enable_q & fire_unmasked_d;
    af_valid_d  = af_active_d;
    af_stamp_d  = af_stamp_q;
    elapsed_d   = '0;
    if (af_active_d) begin
      if (af_valid_q) begin
        elapsed_d = af_dt;
      end else begin
        af_stamp_d = now_ms_i;
      end
    end
  end

  assign status_o.div_needed = af_active_d && (period_d != '0);

  // Persistent state registers, updated once per accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= CS_IDLE;
      seq_stamp_q  <= '0;
      hold_stamp_q <= '0;
      hold_valid_q <= 1'b0;
      prev_menu_q  <= '0;
      prev_sc_q    <= '0;
      suppress_q   <= 1'b0;
      first_q      <= 1'b1;
      demo_q       <= 1'b0;
      af_stamp_q   <= '0;
      af_valid_q   <= 1'b0;
    end else if (cmd_i.load_item) begin
      seq_q        <= seq_d;
      seq_stamp_q  <= seq_stamp_d;
      hold_stamp_q <= hold_stamp_d;
      hold_valid_q <= hold_valid_d;
      prev_menu_q  <= prev_menu_d;
      prev_sc_q    <= prev_sc_d;
      suppress_q   <= suppress_d;
      first_q      <= first_d;
      demo_q       <= demo_d;
      af_stamp_q   <= af_stamp_d;
      af_valid_q   <= af_valid_d;
    end
  end

  // Per-request result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      bs_q            <= bs_d;
      sc_q            <= sc_d;
      fire_unmasked_q <= fire_unmasked_d;
      vol_up_q        <= vol_up_d;
      vol_down_q      <= vol_down_d;
      rst_req_q       <= rst_req_d;
      attract_q       <= attract_d;
      intent_q        <= intent_d;
      af_active_q     <= af_active_d;
      period_q        <= period_d;
      period_zero_q   <= (period_d == '0);
    end
  end

  // Restoring remainder: one dividend bit per step.
  logic [PeriodW:0] trial;
  always_comb begin
    trial = {rem_q, dvd_q[StampW-1]};
    rem_d = rem_q;
    dvd_d = dvd_q;
    if (cmd_i.load_item) begin
      rem_d = '0;
      dvd_d = elapsed_d;
    end else if (cmd_i.div_step) begin
      dvd_d = {dvd_q[StampW-2:0], 1'b0};
      if (trial >= {1'b0, period_q}) begin
        rem_d = PeriodW'(trial - {1'b0, period_q});
      end else begin
        rem_d = trial[PeriodW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  // Fire is masked in the off part of each period and always when the period is zero.
  logic fire_mask;
  assign fire_mask = af_active_q & (period_zero_q | (rem_q >= PeriodW'(af_on_q)));

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      buttons_o         <= {sc_q[1], sc_q[0], bs_q[5], bs_q[4] & !fire_mask, bs_q[3:0]};
      fire_unmasked_o   <= fire_unmasked_q;
      volume_up_o       <= vol_up_q;
      volume_down_o     <= vol_down_q;
      reset_request_o   <= rst_req_q;
      attract_reset_o   <= attract_q;
      play_intent_o     <= intent_q;
      demo_sounds_off_o <= demo_q;
    end
  end

endmodule

`default_nettype wire
